### rtl/mesh_vertex_normal_accumulator_macros.svh
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MVNA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MVNA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/mvna_pkg.sv
// ----------------------------------------------------------------------------
// mvna_pkg
// Types, constants and helpers of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvna_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int IDX_W        = 12;
	localparam int FRAC_BITS    = 14;
	localparam int ACC_W        = 48;
	localparam int POS_W        = 16;
	localparam int DIFF_W       = 17;
	localparam int CROSS_W      = 35;
	localparam int MUL_W        = 32;
	localparam int PROD_W       = 64;
	localparam int VCNT_W       = 13;
	localparam int LSQ_W        = 63;
	localparam int NUM_W        = 45;
	localparam int ROOT_W       = 32;
	localparam int SKIP_W       = 16;
	localparam int CFG_IDX_W    = 1;

	localparam logic [LSQ_W-1:0]  SMALL_LSQ_RESET = 63'd72057594038;
	localparam logic [VCNT_W-1:0] VCOUNT_MAX      = 13'(MAX_VERTICES);

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TRI  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LSQ    = 1'b1;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        vertex_slot;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [IDX_W-1:0]        corner_a;
		logic [IDX_W-1:0]        corner_b;
		logic [IDX_W-1:0]        corner_c;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] normal_x;
		logic signed [POS_W-1:0] normal_y;
		logic signed [POS_W-1:0] normal_z;
		logic                    used_fallback;
		logic [SKIP_W-1:0]       skipped_triangles;
	} out_t;

	typedef struct packed {
		logic                   pos_we;
		logic                   acc_we;
		logic [IDX_W-1:0]       addr;
		logic [3*POS_W-1:0]     pos_wdata;
		logic [3*ACC_W-1:0]     acc_wdata;
	} store_req_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_TRI_RD,
		ST_TRI_CAP,
		ST_TRI_MUL,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_ISSUE,
		ST_RD_CAP,
		ST_LSQ,
		ST_PICK,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT_GO,
		ST_SQRT,
		ST_DIV_GO,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] v);
		mag48 = v[ACC_W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]   a,
		input logic signed [CROSS_W-1:0] d
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {{(ACC_W+1-CROSS_W){d[CROSS_W-1]}}, d};
		if (s[ACC_W] != s[ACC_W-1]) begin
			sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sat_add = s[ACC_W-1:0];
		end
	endfunction

endpackage

### rtl/mvna_store.sv
// ----------------------------------------------------------------------------
// mvna_store
// Position and accumulator memories, one port each, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvna_store (
	input  logic                                  clk,
	input  mvna_pkg::store_req_t                  req,
	output logic [3*mvna_pkg::POS_W-1:0]          pos_rdata,
	output logic [3*mvna_pkg::ACC_W-1:0]          acc_rdata
);

	logic [3*mvna_pkg::POS_W-1:0] pos_mem [mvna_pkg::MAX_VERTICES];
	logic [3*mvna_pkg::ACC_W-1:0] acc_mem [mvna_pkg::MAX_VERTICES];
	logic [3*mvna_pkg::POS_W-1:0] pos_rd_q;
	logic [3*mvna_pkg::ACC_W-1:0] acc_rd_q;

	always_ff @(posedge clk) begin
		if (req.pos_we) begin
			pos_mem[req.addr] <= req.pos_wdata;
		end
		pos_rd_q <= pos_mem[req.addr];
	end

	always_ff @(posedge clk) begin
		if (req.acc_we) begin
			acc_mem[req.addr] <= req.acc_wdata;
		end
		acc_rd_q <= acc_mem[req.addr];
	end

	assign pos_rdata = pos_rd_q;
	assign acc_rdata = acc_rd_q;

endmodule

### rtl/mvna_sqrt.sv
// ----------------------------------------------------------------------------
// mvna_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvna_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mvna_pkg::PROD_W-1:0]       radicand,
	output logic                              done,
	output logic [mvna_pkg::ROOT_W-1:0]       root
);

	logic                          busy_q;
	logic                          done_q;
	logic [mvna_pkg::PROD_W-1:0]   rem_q;
	logic [mvna_pkg::PROD_W-1:0]   res_q;
	logic [mvna_pkg::PROD_W-1:0]   bit_q;
	logic [mvna_pkg::PROD_W-1:0]   trial;
	logic                          fits;

	assign trial = res_q + bit_q;
	assign fits  = rem_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(mvna_pkg::PROD_W-2){1'b0}}};
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[mvna_pkg::ROOT_W-1:0];

endmodule

### rtl/mvna_div.sv
// ----------------------------------------------------------------------------
// mvna_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvna_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mvna_pkg::NUM_W-1:0]       numer,
	input  logic [mvna_pkg::ROOT_W-1:0]      denom,
	output logic                             done,
	output logic [mvna_pkg::NUM_W-1:0]       quot
);

	localparam int CNT_W = $clog2(mvna_pkg::NUM_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [mvna_pkg::NUM_W-1:0]    num_q;
	logic [mvna_pkg::NUM_W-1:0]    quo_q;
	logic [mvna_pkg::ROOT_W-1:0]   rem_q;
	logic [mvna_pkg::ROOT_W-1:0]   den_q;
	logic [mvna_pkg::ROOT_W:0]     part;
	logic                          fits;

	assign part = {rem_q, num_q[mvna_pkg::NUM_W-1]};
	assign fits = part >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mvna_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? mvna_pkg::ROOT_W'(part - {1'b0, den_q})
				: part[mvna_pkg::ROOT_W-1:0];
			quo_q <= {quo_q[mvna_pkg::NUM_W-2:0], fits};
			num_q <= num_q << 1;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

### rtl/mesh_vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Area-weighted per-vertex normals of a triangle mesh, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry load, triangle and read items; one
//   transfer per item. out_valid/out_stall/out_data return one result per
//   read item. cfg_write/cfg_index/cfg_data write vertex_count and small_length_sq;
//   the user must do so only while the block is idle; it is not enforced.
// Items are handled one at a time, bounded by the memory port and the
//   serial root and divide units: a triangle takes three position reads,
//   six products on one multiplier and three accumulator read-modify-writes;
//   a read takes a 32-step square root and three 45-step divides, plus up to
//   18 normalizing shifts.
// A finished result sits in the output register; the next item is taken
//   while it waits. A stalled receiver holds out_data and only blocks the
//   next read item at its last step.
// Reset clears control, vertex_count, out_valid and the skip counter and
//   presets small_length_sq; other registers are not reset, and memory
//   contents are undefined until written by load items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mvna_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mvna_pkg::LSQ_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  mvna_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output mvna_pkg::out_t                       out_data
);

	localparam int PW = mvna_pkg::POS_W;
	localparam int AW = mvna_pkg::ACC_W;

	mvna_pkg::state_t       state_q, state_d;
	logic [2:0]             cnt_q, cnt_d;
	mvna_pkg::in_t          item_q;
	logic [mvna_pkg::VCNT_W-1:0] vcount_q;
	logic [mvna_pkg::LSQ_W-1:0]  small_q;
	logic [mvna_pkg::SKIP_W-1:0] skip_q;
	logic                   out_valid_q;
	mvna_pkg::out_t         out_q;

	logic signed [PW-1:0]   p_q [3][3];
	logic signed [mvna_pkg::CROSS_W-1:0] n_q [3];
	logic signed [AW-1:0]   accv_q [3];
	logic [AW-1:0]          mag_q [3];
	logic [2:0]             neg_q;
	logic [mvna_pkg::PROD_W-1:0] sum_q;
	logic                   fb_q;
	logic [mvna_pkg::ROOT_W-1:0] len_q;
	logic [PW-1:0]          quo_q [3];

	logic signed [mvna_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic signed [mvna_pkg::PROD_W-1:0] mul_p_q;

	logic signed [mvna_pkg::DIFF_W-1:0] u [3];
	logic signed [mvna_pkg::DIFF_W-1:0] w [3];
	logic [AW-1:0]          acc_mag [3];
	logic [mvna_pkg::IDX_W-1:0] corner_sel;
	logic [mvna_pkg::VCNT_W-1:0] lim;
	logic                   skip_hit;
	logic                   in_acc;
	logic                   out_free;
	logic                   big_any;
	logic [mvna_pkg::PROD_W-1:0] lsq;
	logic                   fallback;
	logic                   shift_need;
	logic [2:0]             pidx;

	mvna_pkg::store_req_t   req;
	logic [3*PW-1:0]        pos_rdata;
	logic [3*AW-1:0]        acc_rdata;
	logic signed [AW-1:0]   acc_new [3];

	logic                   sqrt_start, sqrt_done;
	logic [mvna_pkg::ROOT_W-1:0] sqrt_root;
	logic                   div_start, div_done;
	logic [mvna_pkg::NUM_W-1:0]  div_numer, div_quot;

	mvna_store u_store (
		.clk       (clk),
		.req       (req),
		.pos_rdata (pos_rdata),
		.acc_rdata (acc_rdata)
	);

	mvna_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_q),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	mvna_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (len_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign in_acc   = in_valid && (state_q == mvna_pkg::ST_IDLE);
	assign in_stall = state_q != mvna_pkg::ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign lim = (vcount_q > mvna_pkg::VCOUNT_MAX) ? mvna_pkg::VCOUNT_MAX : vcount_q;
	assign skip_hit = ({1'b0, in_data.corner_a} >= lim) || ({1'b0, in_data.corner_b} >= lim)
		|| ({1'b0, in_data.corner_c} >= lim);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    corner_sel = item_q.corner_a;
			2'd1:    corner_sel = item_q.corner_b;
			default: corner_sel = item_q.corner_c;
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u[i] = mvna_pkg::DIFF_W'(p_q[1][i]) - mvna_pkg::DIFF_W'(p_q[0][i]);
			w[i] = mvna_pkg::DIFF_W'(p_q[2][i]) - mvna_pkg::DIFF_W'(p_q[0][i]);
			acc_mag[i] = mvna_pkg::mag48(accv_q[i]);
			acc_new[i] = mvna_pkg::sat_add(
				acc_rdata[(2-i)*AW +: AW], n_q[i]);
		end
	end

	assign big_any = (acc_mag[0][AW-1:31] != '0) || (acc_mag[1][AW-1:31] != '0)
		|| (acc_mag[2][AW-1:31] != '0);
	assign lsq = (big_any || sum_q[mvna_pkg::PROD_W-1]) ? {1'b0, {mvna_pkg::LSQ_W{1'b1}}}
		: sum_q;
	assign fallback = lsq < {1'b0, small_q};
	assign shift_need = (mag_q[0][AW-1:30] != '0) || (mag_q[1][AW-1:30] != '0)
		|| (mag_q[2][AW-1:30] != '0);
	assign pidx = cnt_q - 3'd1;
	assign div_numer = mvna_pkg::NUM_W'({mag_q[cnt_q[1:0]][29:0],
		{mvna_pkg::FRAC_BITS{1'b0}}}) + mvna_pkg::NUM_W'(len_q >> 1);

	// next state
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			mvna_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_acc) begin
					case (in_data.kind)
						mvna_pkg::KIND_TRI:  state_d = skip_hit ? mvna_pkg::ST_IDLE
							: mvna_pkg::ST_TRI_RD;
						mvna_pkg::KIND_READ: state_d = mvna_pkg::ST_RD_ISSUE;
						default:             state_d = mvna_pkg::ST_IDLE;
					endcase
				end
			end
			mvna_pkg::ST_TRI_RD: state_d = mvna_pkg::ST_TRI_CAP;
			mvna_pkg::ST_TRI_CAP: begin
				if (cnt_q == 3'd2) begin
					state_d = mvna_pkg::ST_TRI_MUL;
					cnt_d   = '0;
				end else begin
					state_d = mvna_pkg::ST_TRI_RD;
					cnt_d   = cnt_q + 3'd1;
				end
			end
			mvna_pkg::ST_TRI_MUL: begin
				if (cnt_q == 3'd6) begin
					state_d = mvna_pkg::ST_ACC_RD;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			mvna_pkg::ST_ACC_RD: state_d = mvna_pkg::ST_ACC_WR;
			mvna_pkg::ST_ACC_WR: begin
				if (cnt_q == 3'd2) begin
					state_d = mvna_pkg::ST_IDLE;
					cnt_d   = '0;
				end else begin
					state_d = mvna_pkg::ST_ACC_RD;
					cnt_d   = cnt_q + 3'd1;
				end
			end
			mvna_pkg::ST_RD_ISSUE: state_d = mvna_pkg::ST_RD_CAP;
			mvna_pkg::ST_RD_CAP: begin
				state_d = mvna_pkg::ST_LSQ;
				cnt_d   = '0;
			end
			mvna_pkg::ST_LSQ: begin
				if (cnt_q == 3'd3) begin
					state_d = mvna_pkg::ST_PICK;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			mvna_pkg::ST_PICK: state_d = mvna_pkg::ST_SHIFT;
			mvna_pkg::ST_SHIFT: begin
				if (!shift_need) begin
					state_d = mvna_pkg::ST_SQ;
					cnt_d   = '0;
				end
			end
			mvna_pkg::ST_SQ: begin
				if (cnt_q == 3'd3) begin
					state_d = mvna_pkg::ST_SQRT_GO;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			mvna_pkg::ST_SQRT_GO: state_d = mvna_pkg::ST_SQRT;
			mvna_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					state_d = mvna_pkg::ST_DIV_GO;
					cnt_d   = '0;
				end
			end
			mvna_pkg::ST_DIV_GO: state_d = mvna_pkg::ST_DIV;
			mvna_pkg::ST_DIV: begin
				if (div_done) begin
					if (cnt_q == 3'd2) begin
						state_d = mvna_pkg::ST_EMIT;
						cnt_d   = '0;
					end else begin
						state_d = mvna_pkg::ST_DIV_GO;
						cnt_d   = cnt_q + 3'd1;
					end
				end
			end
			mvna_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = mvna_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mvna_pkg::ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	// outputs: memory port, multiplier operands, unit starts
	always_comb begin
		req           = '0;
		req.addr      = item_q.vertex_slot;
		mul_a         = '0;
		mul_b         = '0;
		sqrt_start    = 1'b0;
		div_start     = 1'b0;
		case (state_q)
			mvna_pkg::ST_IDLE: begin
				if (in_acc && (in_data.kind == mvna_pkg::KIND_LOAD)) begin
					req.pos_we    = 1'b1;
					req.acc_we    = 1'b1;
					req.addr      = in_data.vertex_slot;
					req.pos_wdata = {in_data.pos_x, in_data.pos_y, in_data.pos_z};
				end
			end
			mvna_pkg::ST_TRI_RD: req.addr = corner_sel;
			mvna_pkg::ST_TRI_MUL: begin
				case (cnt_q)
					3'd0: begin mul_a = mvna_pkg::MUL_W'(u[1]); mul_b = mvna_pkg::MUL_W'(w[2]); end
					3'd1: begin mul_a = mvna_pkg::MUL_W'(u[2]); mul_b = mvna_pkg::MUL_W'(w[1]); end
					3'd2: begin mul_a = mvna_pkg::MUL_W'(u[2]); mul_b = mvna_pkg::MUL_W'(w[0]); end
					3'd3: begin mul_a = mvna_pkg::MUL_W'(u[0]); mul_b = mvna_pkg::MUL_W'(w[2]); end
					3'd4: begin mul_a = mvna_pkg::MUL_W'(u[0]); mul_b = mvna_pkg::MUL_W'(w[1]); end
					3'd5: begin mul_a = mvna_pkg::MUL_W'(u[1]); mul_b = mvna_pkg::MUL_W'(w[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			mvna_pkg::ST_ACC_RD: req.addr = corner_sel;
			mvna_pkg::ST_ACC_WR: begin
				req.addr      = corner_sel;
				req.acc_we    = 1'b1;
				req.acc_wdata = {acc_new[0], acc_new[1], acc_new[2]};
			end
			mvna_pkg::ST_LSQ: begin
				if (cnt_q != 3'd3) begin
					mul_a = {1'b0, acc_mag[cnt_q[1:0]][30:0]};
					mul_b = {1'b0, acc_mag[cnt_q[1:0]][30:0]};
				end
			end
			mvna_pkg::ST_SQ: begin
				if (cnt_q != 3'd3) begin
					mul_a = {1'b0, mag_q[cnt_q[1:0]][30:0]};
					mul_b = {1'b0, mag_q[cnt_q[1:0]][30:0]};
				end
			end
			mvna_pkg::ST_SQRT_GO: sqrt_start = 1'b1;
			mvna_pkg::ST_DIV_GO:  div_start  = 1'b1;
			default: begin
				req.addr = item_q.vertex_slot;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mvna_pkg::ST_IDLE;
			cnt_q       <= '0;
			vcount_q    <= '0;
			small_q     <= mvna_pkg::SMALL_LSQ_RESET;
			skip_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_write) begin
				case (cfg_index)
					mvna_pkg::CFG_VERTEX_COUNT: vcount_q <= cfg_data[mvna_pkg::VCNT_W-1:0];
					mvna_pkg::CFG_SMALL_LSQ:    small_q  <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc && (in_data.kind == mvna_pkg::KIND_TRI) && skip_hit
				&& (skip_q != '1)) begin
				skip_q <= skip_q + 1'b1;
			end
			if ((state_q == mvna_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= mul_a * mul_b;
		if (in_acc) begin
			item_q <= in_data;
		end
		case (state_q)
			mvna_pkg::ST_TRI_CAP: begin
				for (int i = 0; i < 3; i++) begin
					p_q[cnt_q[1:0]][i] <= pos_rdata[(2-i)*PW +: PW];
				end
			end
			mvna_pkg::ST_TRI_MUL: begin
				if (cnt_q != 3'd0) begin
					if (!pidx[0]) begin
						n_q[pidx[2:1]] <= mul_p_q[mvna_pkg::CROSS_W-1:0];
					end else begin
						n_q[pidx[2:1]] <= n_q[pidx[2:1]] - mul_p_q[mvna_pkg::CROSS_W-1:0];
					end
				end
			end
			mvna_pkg::ST_RD_CAP: begin
				for (int i = 0; i < 3; i++) begin
					accv_q[i]  <= acc_rdata[(2-i)*AW +: AW];
					p_q[0][i]  <= pos_rdata[(2-i)*PW +: PW];
				end
				sum_q <= '0;
			end
			mvna_pkg::ST_LSQ, mvna_pkg::ST_SQ: begin
				if (cnt_q != 3'd0) begin
					sum_q <= sum_q + mul_p_q;
				end
			end
			mvna_pkg::ST_PICK: begin
				fb_q  <= fallback;
				sum_q <= '0;
				for (int i = 0; i < 3; i++) begin
					if (fallback) begin
						mag_q[i] <= mvna_pkg::mag48(AW'(p_q[0][i]));
						neg_q[i] <= p_q[0][i][PW-1];
					end else begin
						mag_q[i] <= acc_mag[i];
						neg_q[i] <= accv_q[i][AW-1];
					end
				end
			end
			mvna_pkg::ST_SHIFT: begin
				if (shift_need) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_q[i] >> 1;
					end
				end
			end
			mvna_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					len_q <= sqrt_root;
				end
			end
			mvna_pkg::ST_DIV: begin
				if (div_done) begin
					if (len_q == '0) begin
						quo_q[cnt_q[1:0]] <= '0;
					end else if (neg_q[cnt_q[1:0]]) begin
						quo_q[cnt_q[1:0]] <= ~div_quot[PW-1:0] + 1'b1;
					end else begin
						quo_q[cnt_q[1:0]] <= div_quot[PW-1:0];
					end
				end
			end
			mvna_pkg::ST_EMIT: begin
				if (out_free) begin
					out_q.normal_x          <= quo_q[0];
					out_q.normal_y          <= quo_q[1];
					out_q.normal_z          <= quo_q[2];
					out_q.used_fallback     <= fb_q;
					out_q.skipped_triangles <= skip_q;
				end
			end
			default: ;
		endcase
	end

endmodule

### rtl/mvna_check.sv
// ----------------------------------------------------------------------------
// mvna_check
// Port-level checker for the vertex normal accumulator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mesh_vertex_normal_accumulator_macros.svh"

module mvna_check (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [mvna_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mvna_pkg::LSQ_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  mvna_pkg::in_t                        in_data,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  mvna_pkg::out_t                       out_data
);

	logic in_xfer;
	assign in_xfer = in_valid && !in_stall;

	`MVNA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
	`MVNA_ASSERT_NXT(a_read_busy, in_xfer && (in_data.kind == mvna_pkg::KIND_READ), in_stall, "read transfer did not start work")
	`MVNA_ASSERT_NXT(a_load_quick, in_xfer && (in_data.kind == mvna_pkg::KIND_LOAD), !in_stall, "load transfer held input")
	`MVNA_ASSERT_NOW(a_rise_busy, $rose(out_valid), $past(in_stall), "result without work in progress")

endmodule

bind mesh_vertex_normal_accumulator mvna_check u_check (.*);
